/* sv/qit_pkg.sv */
package qit_pkg;

  // Command codes of an input item
  localparam logic [1:0] CMD_STORE  = 2'd0;
  localparam logic [1:0] CMD_ACK    = 2'd1;
  localparam logic [1:0] CMD_PUBREC = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_STORED      = 3'd0;
  localparam logic [2:0] ST_FULL        = 3'd1;
  localparam logic [2:0] ST_ACKED       = 3'd2;
  localparam logic [2:0] ST_UNKNOWN     = 3'd3;
  localparam logic [2:0] ST_SEND_REL    = 3'd4;
  localparam logic [2:0] ST_REC_NOMATCH = 3'd5;
  localparam logic [2:0] ST_RESEND_PUB  = 3'd6;
  localparam logic [2:0] ST_RESEND_REL  = 3'd7;

  localparam logic [31:0] RETRY_RESET = 32'd5000;
  localparam logic [1:0]  QOS_TWO     = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic start;      // latch item, restart the scan
    logic adv;        // issue next table read, move it into evaluation
    logic commit;     // apply the table update of the evaluated slot
    logic emit_hit;   // load output with the match result
    logic emit_miss;  // load output with the no-match result
    logic emit_held;  // load output with the held retransmit
    logic held_last;  // last flag for the held retransmit
    logic load_held;  // capture the evaluated retransmit into the hold register
  } qit_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ev_v;
    logic ev_hit;
    logic ev_last;
    logic is_tick;
    logic out_free;
    logic held_v;
  } qit_sts_t;

endpackage

/* sv/qit_in_if.sv */
interface qit_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] msg_id;
  logic [1:0]  qos_level;
  logic [31:0] now_ms;

  modport source (output valid, command, msg_id, qos_level, now_ms, input ready);
  modport sink   (input valid, command, msg_id, qos_level, now_ms, output ready);
endinterface

/* sv/qit_out_if.sv */
interface qit_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic [15:0] entry_msg_id;
  logic        last;

  modport source (output valid, status, slot, entry_msg_id, last, input ready);
  modport sink   (input valid, status, slot, entry_msg_id, last, output ready);
endinterface

/* sv/qit_ctrl.sv */
module qit_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qit_pkg::qit_sts_t sts,
  output qit_pkg::qit_cmd_t cmd
);
  import qit_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.ev_v) begin
          cmd.adv = 1'b1;
        end else if (!sts.is_tick) begin
          if (sts.ev_hit) begin
            if (sts.out_free) begin
              cmd.emit_hit = 1'b1;
              cmd.commit   = 1'b1;
              state_nxt    = S_IDLE;
            end
          end else if (sts.ev_last) begin
            if (sts.out_free) begin
              cmd.emit_miss = 1'b1;
              state_nxt     = S_IDLE;
            end
          end else begin
            cmd.adv = 1'b1;
          end
        end else if (sts.ev_hit) begin
          // push the older retransmit out before holding this one
          if (!sts.held_v || sts.out_free) begin
            cmd.commit    = 1'b1;
            cmd.load_held = 1'b1;
            cmd.emit_held = sts.held_v;
            if (sts.ev_last) begin
              state_nxt = S_FLUSH;
            end else begin
              cmd.adv = 1'b1;
            end
          end
        end else if (sts.ev_last) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!sts.held_v) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_held = 1'b1;
          cmd.held_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_hit || cmd.emit_miss || cmd.emit_held) |-> sts.out_free)
    else $error("result emitted while output register is occupied");

  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_hit, cmd.emit_miss, cmd.emit_held}))
    else $error("more than one result source in one cycle");

  a_commit_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (sts.ev_v && sts.ev_hit))
    else $error("table update without a matching evaluated slot");

endmodule

/* sv/qit_dp.sv */
module qit_dp #(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic [1:0]        in_command,
  input  logic [15:0]       in_msg_id,
  input  logic [1:0]        in_qos_level,
  input  logic [31:0]       in_now_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [3:0]        out_slot,
  output logic [15:0]       out_entry_msg_id,
  output logic              out_last,
  input  qit_pkg::qit_cmd_t cmd,
  output qit_pkg::qit_sts_t sts
);
  import qit_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  logic [31:0] interval_r;

  logic [1:0]  cmd_r;
  logic [15:0] id_r;
  logic        qos2_r;
  logic [31:0] now_r;

  logic [SLOTS-1:0] valid_r;
  logic [15:0] mem_id   [SLOTS];
  logic        mem_q2   [SLOTS];
  logic        mem_wait [SLOTS];
  logic [31:0] mem_time [SLOTS];

  logic [IW-1:0] rd_idx_r;
  logic [IW-1:0] ev_idx_r;
  logic          ev_v_r;
  logic [15:0]   rid_r;
  logic          rq2_r;
  logic          rwait_r;
  logic [31:0]   rtime_r;

  logic          held_v_r;
  logic [2:0]    held_status_r;
  logic [3:0]    held_slot_r;
  logic [15:0]   held_id_r;

  logic          o_v_r;
  logic [2:0]    o_status_r;
  logic [3:0]    o_slot_r;
  logic [15:0]   o_id_r;
  logic          o_last_r;

  logic          ev_valid;
  logic          ev_hit;
  logic          id_eq;
  logic          due;
  logic [31:0]   age;
  logic [2:0]    hit_status;
  logic [2:0]    miss_status;
  logic [3:0]    ev_slot;
  logic          out_free;

  assign ev_valid = valid_r[ev_idx_r];
  assign id_eq    = (rid_r == id_r);
  assign age      = now_r - rtime_r;
  assign due      = (age >= interval_r);
  assign ev_slot  = 4'(ev_idx_r);
  assign out_free = !o_v_r || out_ready;

  always_comb begin
    unique case (cmd_r)
      CMD_STORE: begin
        ev_hit      = !ev_valid;
        hit_status  = ST_STORED;
        miss_status = ST_FULL;
      end
      CMD_ACK: begin
        ev_hit      = ev_valid && id_eq;
        hit_status  = ST_ACKED;
        miss_status = ST_UNKNOWN;
      end
      CMD_PUBREC: begin
        ev_hit      = ev_valid && id_eq && rq2_r && !rwait_r;
        hit_status  = ST_SEND_REL;
        miss_status = ST_REC_NOMATCH;
      end
      CMD_TICK: begin
        ev_hit      = ev_valid && due;
        hit_status  = (rq2_r && rwait_r) ? ST_RESEND_REL : ST_RESEND_PUB;
        miss_status = ST_RESEND_PUB;
      end
      default: begin
        ev_hit      = 1'b0;
        hit_status  = ST_STORED;
        miss_status = ST_FULL;
      end
    endcase
  end

  assign sts.ev_v     = ev_v_r;
  assign sts.ev_hit   = ev_hit;
  assign sts.ev_last  = (ev_idx_r == LAST_IDX);
  assign sts.is_tick  = (cmd_r == CMD_TICK);
  assign sts.out_free = out_free;
  assign sts.held_v   = held_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= RETRY_RESET;
    end else if (cfg_we) begin
      interval_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_r  <= in_command;
      id_r   <= in_msg_id;
      qos2_r <= (in_qos_level == QOS_TWO);
      now_r  <= in_now_ms;
    end
  end

  // scan pipeline: read slot into registers, then evaluate the registered copy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_v_r   <= 1'b0;
      rd_idx_r <= '0;
      ev_idx_r <= '0;
    end else if (cmd.start) begin
      ev_v_r   <= 1'b0;
      rd_idx_r <= '0;
    end else if (cmd.adv) begin
      ev_v_r   <= 1'b1;
      ev_idx_r <= rd_idx_r;
      rd_idx_r <= (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.adv) begin
      rid_r   <= mem_id[rd_idx_r];
      rq2_r   <= mem_q2[rd_idx_r];
      rwait_r <= mem_wait[rd_idx_r];
      rtime_r <= mem_time[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      unique case (cmd_r)
        CMD_STORE: begin
          mem_id[ev_idx_r]   <= id_r;
          mem_q2[ev_idx_r]   <= qos2_r;
          mem_wait[ev_idx_r] <= 1'b0;
          mem_time[ev_idx_r] <= now_r;
        end
        CMD_PUBREC: begin
          mem_wait[ev_idx_r] <= 1'b1;
          mem_time[ev_idx_r] <= now_r;
        end
        CMD_TICK: begin
          mem_time[ev_idx_r] <= now_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && (cmd_r == CMD_STORE)) begin
      valid_r[ev_idx_r] <= 1'b1;
    end else if (cmd.commit && (cmd_r == CMD_ACK)) begin
      valid_r[ev_idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r <= 1'b0;
    end else if (cmd.start) begin
      held_v_r <= 1'b0;
    end else if (cmd.load_held) begin
      held_v_r <= 1'b1;
    end else if (cmd.emit_held && cmd.held_last) begin
      held_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_held) begin
      held_status_r <= hit_status;
      held_slot_r   <= ev_slot;
      held_id_r     <= rid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (cmd.emit_hit || cmd.emit_miss || cmd.emit_held) begin
      o_v_r <= 1'b1;
    end else if (out_ready) begin
      o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_held) begin
      o_status_r <= held_status_r;
      o_slot_r   <= held_slot_r;
      o_id_r     <= held_id_r;
      o_last_r   <= cmd.held_last;
    end else if (cmd.emit_hit) begin
      o_status_r <= hit_status;
      o_slot_r   <= ev_slot;
      o_id_r     <= id_r;
      o_last_r   <= 1'b1;
    end else if (cmd.emit_miss) begin
      o_status_r <= miss_status;
      o_slot_r   <= 4'd0;
      o_id_r     <= id_r;
      o_last_r   <= 1'b1;
    end
  end

  assign out_valid        = o_v_r;
  assign out_status       = o_status_r;
  assign out_slot         = o_slot_r;
  assign out_entry_msg_id = o_id_r;
  assign out_last         = o_last_r;

  a_store_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (cmd_r == CMD_STORE)) |=> valid_r[$past(ev_idx_r)])
    else $error("stored slot not marked valid");

  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (cmd_r == CMD_ACK)) |=> !valid_r[$past(ev_idx_r)])
    else $error("acked slot still valid");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_hit || cmd.emit_miss || cmd.emit_held) |=> o_v_r)
    else $error("emitted result not presented");

endmodule

/* sv/qos_inflight_retransmit_table.sv */
// Channel  | Dir | Payload                                  | Handshake
// in_ch    | in  | command, msg_id, qos_level, now_ms       | valid/ready
// out_ch   | out | status, slot, entry_msg_id, last         | valid/ready
// cfg      | in  | retry_interval_ms (cfg_wdata)            | cfg_we strobe
//
// Every item scans the slot table one slot per cycle through a registered read,
// unless a stalled output holds the scan; a tick releases its final retransmit
// in a flush step after the scan.
// Synchronous active-low reset clears the valid bits and the control; no
// clearing pass is needed, so items are taken from the first cycle after reset.
// A stalled output holds the scan when a result must be placed; a new item is
// accepted while the last result of the previous one still waits.
module qos_inflight_retransmit_table #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  qit_in_if.sink      in_ch,
  qit_out_if.source   out_ch
);
  import qit_pkg::*;

  qit_cmd_t cmd;
  qit_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  // Sequence the scan: start, advance, commit, and place results.
  qit_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the slot table, the match logic and the output register.
  qit_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_command       (in_ch.command),
    .in_msg_id        (in_ch.msg_id),
    .in_qos_level     (in_ch.qos_level),
    .in_now_ms        (in_ch.now_ms),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_slot         (out_ch.slot),
    .out_entry_msg_id (out_ch.entry_msg_id),
    .out_last         (out_ch.last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
